// File: src/view_space_vertex_projector_macros.svh
// Assertion macros for the view space vertex projector
`ifndef VIEW_SPACE_VERTEX_PROJECTOR_MACROS_SVH
`define VIEW_SPACE_VERTEX_PROJECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a property outside reset
`define VSVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vsvp assertion failed");
// Check a property at every edge, reset included
`define VSVP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vsvp assertion failed");
`else
`define VSVP_ASSERT(lbl, prop)
`define VSVP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: src/vsvp_pkg.sv
package vsvp_pkg;

  localparam int CoordW    = 32;
  localparam int RotW      = 16;
  localparam int RowW      = 48;
  localparam int EyeW      = 31;
  localparam int DifW      = 33;
  localparam int ProdW     = 49;
  localparam int AccW      = 51;
  localparam int RndW      = 40;
  localparam int NumW      = 63;
  localparam int DivSteps  = 4;
  localparam int DivStages = 8;
  localparam int CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_ORIGIN_Z = 3'd5,
    REG_EYE      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][RowW-1:0]          rot;
    logic [2:0][CoordW-1:0]        origin;
    logic [EyeW-1:0]               eye;
  } cfg_t;

  // Round half up from Q.30 to Q16.16
  function automatic logic signed [RndW-1:0] rnd14(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] t;
    t = (a + 51'sd8192) >>> 14;
    return t[RndW-1:0];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [RndW-1:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    else if (v < -40'sd2147483648) return 32'sh80000000;
    else return v[CoordW-1:0];
  endfunction

endpackage

// File: src/view_space_vertex_projector.sv
// Channel   | Direction | Payload
// s_*       | in        | tdata: vx[31:0], vy[63:32], vz[95:64]
// m_*       | out       | tdata: draw_x, draw_y, draw_z; tuser: eye_plane_hit
// cfg_*     | in        | cfg_index selects register, cfg_data holds value
//
// One word enters per cycle while the pipeline advances.
// Depth is set by the 8-stage radix-16 divider and the two rotation passes.
// All stages advance together; when the output word is held, the whole
// pipeline holds and s_tready drops. Synchronous reset clears valid bits
// and loads the identity rotation, zero origin and eye distance 3.0.
`include "view_space_vertex_projector_macros.svh"
module view_space_vertex_projector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [3*vsvp_pkg::CoordW-1:0]     s_tdata,   // vx, vy, vz
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [3*vsvp_pkg::CoordW-1:0]     m_tdata,   // draw_x, draw_y, draw_z
  output logic                              m_tuser,   // eye_plane_hit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vsvp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [vsvp_pkg::RowW-1:0]         cfg_data
);

  vsvp_pkg::cfg_t cfg;
  logic adv;
  logic view_valid, proj_valid, hit;
  logic signed [2:0][vsvp_pkg::CoordW-1:0] vin, view, draw;
  logic signed [1:0][vsvp_pkg::CoordW-1:0] proj;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign vin       = s_tdata;
  assign m_tdata   = draw;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot[0]    <= 48'd16384;
      cfg.rot[1]    <= 48'd1073741824;
      cfg.rot[2]    <= 48'd70368744177664;
      cfg.origin    <= '0;
      cfg.eye       <= 31'd196608;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vsvp_pkg::REG_ROT_ROW0: cfg.rot[0] <= cfg_data;
        vsvp_pkg::REG_ROT_ROW1: cfg.rot[1] <= cfg_data;
        vsvp_pkg::REG_ROT_ROW2: cfg.rot[2] <= cfg_data;
        vsvp_pkg::REG_ORIGIN_X: cfg.origin[0] <= cfg_data[vsvp_pkg::CoordW-1:0];
        vsvp_pkg::REG_ORIGIN_Y: cfg.origin[1] <= cfg_data[vsvp_pkg::CoordW-1:0];
        vsvp_pkg::REG_ORIGIN_Z: cfg.origin[2] <= cfg_data[vsvp_pkg::CoordW-1:0];
        vsvp_pkg::REG_EYE:      cfg.eye <= cfg_data[vsvp_pkg::EyeW-1:0];
        default: ;
      endcase
    end
  end

  vsvp_fwd u_fwd (
    .clk, .rst, .adv,
    .in_valid (s_tvalid),
    .vin, .cfg, .view_valid, .view
  );

  vsvp_proj u_proj (
    .clk, .rst, .adv, .view_valid, .view,
    .eye (cfg.eye),
    .proj_valid, .proj, .hit
  );

  vsvp_back u_back (
    .clk, .rst, .adv, .proj_valid, .proj, .hit, .cfg,
    .out_valid (m_tvalid),
    .draw,
    .out_hit (m_tuser)
  );

  // A divisor-zero word lands on the origin
  `VSVP_ASSERT(a_hit_origin, m_tvalid && m_tuser |-> draw[0] == cfg.origin[0] && draw[1] == cfg.origin[1] && draw[2] == cfg.origin[2])
  // Reset empties the output stage
  `VSVP_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid)

endmodule

// File: src/vsvp_fwd.sv
module vsvp_fwd (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [2:0][vsvp_pkg::CoordW-1:0] vin,
  input  vsvp_pkg::cfg_t                      cfg,
  output logic                                view_valid,
  output logic signed [2:0][vsvp_pkg::CoordW-1:0] view
);

  logic                                     v1, v2;
  logic signed [vsvp_pkg::DifW-1:0]          dif [3];
  logic signed [vsvp_pkg::ProdW-1:0]         prod [3][3];

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      view_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      view_valid <= v2;
    end
  end

  // Offset from origin, then the nine products, then round the column sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dif[i] <= {vin[i][vsvp_pkg::CoordW-1], vin[i]}
                - {cfg.origin[i][vsvp_pkg::CoordW-1], cfg.origin[i]};
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= dif[i] * $signed(cfg.rot[i][vsvp_pkg::RotW*j +: vsvp_pkg::RotW]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        view[j] <= vsvp_pkg::sat32(vsvp_pkg::rnd14(
                     vsvp_pkg::AccW'(prod[0][j]) + vsvp_pkg::AccW'(prod[1][j])
                   + vsvp_pkg::AccW'(prod[2][j])));
      end
    end
  end

endmodule

// File: src/vsvp_proj.sv
module vsvp_proj (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                view_valid,
  input  logic signed [2:0][vsvp_pkg::CoordW-1:0] view,
  input  logic [vsvp_pkg::EyeW-1:0]           eye,
  output logic                                proj_valid,
  output logic signed [1:0][vsvp_pkg::CoordW-1:0] proj,
  output logic                                hit
);

  localparam int W = vsvp_pkg::CoordW;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] low;
    logic [W-1:0] q;
    logic         ovf;
    logic         neg;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]  lane;
    logic [W-1:0] dm;
    logic         hit;
  } div_t;

  // Magnitude and sign stage
  logic                 v4, v5;
  logic [1:0][W-1:0]    mag4;
  logic [1:0]           sgn4;
  logic signed [W+1:0]  den4;
  // Numerator stage
  logic [1:0][vsvp_pkg::NumW-1:0] num5;
  logic [1:0]           neg5;
  logic [W-1:0]         dm5;
  logic                 hit5;

  logic  dv [vsvp_pkg::DivStages+1];
  div_t  dq [vsvp_pkg::DivStages+1];

  // One restoring step: shift in a numerator bit, subtract if it fits
  function automatic lane_t div_step(input lane_t l, input logic [W-1:0] dm);
    logic [W:0] r;
    lane_t      o;
    r = {l.rem, l.low[W-1]};
    o = l;
    o.low = {l.low[W-2:0], 1'b0};
    if (r >= {1'b0, dm}) begin
      o.rem = W'(r - {1'b0, dm});
      o.q   = {l.q[W-2:0], 1'b1};
    end else begin
      o.rem = r[W-1:0];
      o.q   = {l.q[W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Split view x, y into sign and magnitude; form the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      v4 <= view_valid;
      v5 <= v4;
      dv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        sgn4[i] <= view[i][W-1];
        mag4[i] <= view[i][W-1] ? W'(-view[i]) : W'(view[i]);
      end
      den4 <= $signed({3'b000, eye}) - $signed({{2{view[2][W-1]}}, view[2]});
      // Multiply eye by magnitude; take divisor magnitude
      for (int i = 0; i < 2; i++) begin
        num5[i] <= eye * mag4[i];
        neg5[i] <= sgn4[i] ^ den4[W+1];
      end
      dm5  <= den4[W+1] ? W'(-den4) : W'(den4);
      hit5 <= (den4 == '0);
      // Overflow check and divider set-up
      for (int i = 0; i < 2; i++) begin
        dq[0].lane[i].ovf <= {1'b0, num5[i]} >= {dm5, {W{1'b0}}};
        dq[0].lane[i].rem <= W'(num5[i][vsvp_pkg::NumW-1:W]);
        dq[0].lane[i].low <= num5[i][W-1:0];
        dq[0].lane[i].q   <= '0;
        dq[0].lane[i].neg <= neg5[i];
      end
      dq[0].dm  <= dm5;
      dq[0].hit <= hit5;
    end
  end

  // Divider stages, four quotient bits each
  for (genvar k = 0; k < vsvp_pkg::DivStages; k++) begin : g_div
    div_t nxt;
    always_comb begin
      nxt = dq[k];
      for (int s = 0; s < vsvp_pkg::DivSteps; s++) begin
        nxt.lane[0] = div_step(nxt.lane[0], dq[k].dm);
        nxt.lane[1] = div_step(nxt.lane[1], dq[k].dm);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dq[k+1] <= nxt;
      end
    end
  end

  // Apply sign and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      proj_valid <= 1'b0;
    end else if (adv) begin
      proj_valid <= dv[vsvp_pkg::DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= dq[vsvp_pkg::DivStages].hit;
      for (int i = 0; i < 2; i++) begin
        if (dq[vsvp_pkg::DivStages].hit) begin
          proj[i] <= '0;
        end else if (dq[vsvp_pkg::DivStages].lane[i].neg) begin
          if (dq[vsvp_pkg::DivStages].lane[i].ovf ||
              dq[vsvp_pkg::DivStages].lane[i].q > {1'b1, {(W-1){1'b0}}}) begin
            proj[i] <= {1'b1, {(W-1){1'b0}}};
          end else begin
            proj[i] <= -dq[vsvp_pkg::DivStages].lane[i].q;
          end
        end else begin
          if (dq[vsvp_pkg::DivStages].lane[i].ovf || dq[vsvp_pkg::DivStages].lane[i].q[W-1]) begin
            proj[i] <= {1'b0, {(W-1){1'b1}}};
          end else begin
            proj[i] <= dq[vsvp_pkg::DivStages].lane[i].q;
          end
        end
      end
    end
  end

endmodule

// File: src/vsvp_back.sv
module vsvp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                proj_valid,
  input  logic signed [1:0][vsvp_pkg::CoordW-1:0] proj,
  input  logic                                hit,
  input  vsvp_pkg::cfg_t                      cfg,
  output logic                                out_valid,
  output logic signed [2:0][vsvp_pkg::CoordW-1:0] draw,
  output logic                                out_hit
);

  logic                                    v15, h15;
  logic signed [vsvp_pkg::CoordW+vsvp_pkg::RotW-1:0] bp [3][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v15 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v15 <= proj_valid;
      out_valid <= v15;
    end
  end

  // Transposed rotation products, then round, add origin and clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      h15 <= hit;
      out_hit <= h15;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 2; i++) begin
          bp[j][i] <= $signed(proj[i])
                    * $signed(cfg.rot[j][vsvp_pkg::RotW*i +: vsvp_pkg::RotW]);
        end
        draw[j] <= vsvp_pkg::sat32(
                     vsvp_pkg::rnd14(vsvp_pkg::AccW'(bp[j][0]) + vsvp_pkg::AccW'(bp[j][1]))
                   + $signed({{(vsvp_pkg::RndW-vsvp_pkg::CoordW){cfg.origin[j][vsvp_pkg::CoordW-1]}},
                              cfg.origin[j]}));
      end
    end
  end

endmodule
